// ----- rtl/bitmap_block_allocator_core_macros.svh -----
// Assertion macros for the bitmap block allocator.
// Included by files that carry concurrent checks; no other dependency.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every clock edge outside reset
`define BBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never occurs outside reset
`define BBA_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rst, prop, msg)
`define BBA_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ----- rtl/bba_pkg.sv -----
// Shared types and constants of the bitmap block allocator.
// No dependencies; used by the map RAM, the controller and the top level.
`default_nettype none

package bba_pkg;

  // Map geometry
  localparam int NUM_BLOCKS = 65536;
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = NUM_BLOCKS / WORD_BITS;
  localparam int ADDR_W     = $clog2(MAP_WORDS);
  localparam int WCNT_W     = ADDR_W + 1;

  // Field widths
  localparam int IDX_W   = 16;
  localparam int LIMIT_W = 17;

  // Limit handling
  localparam int INDEX_SPAN = 65536;
  localparam int LIMIT_CAP  = (NUM_BLOCKS < INDEX_SPAN) ? NUM_BLOCKS : INDEX_SPAN;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(LIMIT_CAP);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65454);

  // Request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_DONE
  } bba_state_t;

  // Map RAM access from the controller
  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
  } bba_mem_req_t;

  // Finished result offered to the output register
  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [IDX_W-1:0] idx;
  } bba_result_t;

  // Controller status
  typedef struct packed {
    logic in_ready;
    logic clearing;
  } bba_status_t;

endpackage

`default_nettype wire

// ----- rtl/bba_map_ram.sv -----
// Usage map storage: one bit per block, one write and one read port.
// Depends on bba_pkg for geometry and the request struct.
`default_nettype none

module bba_map_ram (
  input  wire logic                          clk,
  input  wire bba_pkg::bba_mem_req_t         req,
  output logic [bba_pkg::WORD_BITS-1:0]      rdata
);

  logic [bba_pkg::WORD_BITS-1:0] mem [bba_pkg::MAP_WORDS];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/bba_ctrl.sv -----
// Allocator sequencer: clears the map after reset, scans it first-fit for
// allocations and does read-modify-write for frees. Depends on bba_pkg.
`default_nettype none

module bba_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic                             in_action,
  input  wire logic [bba_pkg::IDX_W-1:0]        in_index,
  input  wire logic [bba_pkg::LIMIT_W-1:0]      lim,
  output bba_pkg::bba_mem_req_t                 mem_req,
  input  wire logic [bba_pkg::WORD_BITS-1:0]    mem_rdata,
  output bba_pkg::bba_result_t                  res,
  input  wire logic                             res_ready,
  output bba_pkg::bba_status_t                  status
);

  localparam int AW = bba_pkg::ADDR_W;
  localparam int BW = bba_pkg::BIT_W;
  localparam int WB = bba_pkg::WORD_BITS;
  localparam int CW = bba_pkg::WCNT_W;

  bba_pkg::bba_state_t state, state_next;

  logic [AW-1:0]             clr_addr, clr_addr_next;
  logic [CW-1:0]             rd_addr, rd_addr_next;
  logic                      rd_pend, rd_pend_next;
  logic [AW-1:0]             rd_word, rd_word_next;
  logic [bba_pkg::IDX_W-1:0] tgt, tgt_next;
  logic                      res_ok, res_ok_next;
  logic [bba_pkg::IDX_W-1:0] res_idx, res_idx_next;

  logic [bba_pkg::LIMIT_W:0] words_sum;
  logic [CW-1:0]             words;
  logic [CW-1:0]             lim_word;
  logic [WB-1:0]             mask;
  logic [WB-1:0]             free_bits;
  logic                      hit;
  logic                      more;
  logic [BW-1:0]             hit_bit;

  // Lowest set bit of a map word
  function automatic logic [BW-1:0] lowest_set(input logic [WB-1:0] v);
    logic [BW-1:0] pos;
    pos = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = BW'(i);
      end
    end
    return pos;
  endfunction

  // Number of map words that hold usable blocks
  assign words_sum = {1'b0, lim} + (bba_pkg::LIMIT_W + 1)'(WB - 1);
  assign words     = words_sum[bba_pkg::LIMIT_W-1:BW];
  assign lim_word  = lim[bba_pkg::LIMIT_W-1:BW];

  // Keep only free bits of the returned word that lie below the limit
  always_comb begin
    for (int b = 0; b < WB; b++) begin
      mask[b] = ({1'b0, rd_word} < lim_word) ||
                (({1'b0, rd_word} == lim_word) && (BW'(b) < lim[BW-1:0]));
    end
  end

  assign free_bits = ~mem_rdata & mask;
  assign hit       = rd_pend && (|free_bits);
  assign hit_bit   = lowest_set(free_bits);
  assign more      = rd_addr < words;

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bba_pkg::ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      rd_pend  <= rd_pend_next;
    end
    rd_addr <= rd_addr_next;
    rd_word <= rd_word_next;
    tgt     <= tgt_next;
    res_ok  <= res_ok_next;
    res_idx <= res_idx_next;
  end

  // Next state, memory requests and results
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    rd_addr_next  = rd_addr;
    rd_pend_next  = 1'b0;
    rd_word_next  = rd_word;
    tgt_next      = tgt;
    res_ok_next   = res_ok;
    res_idx_next  = res_idx;
    mem_req       = '0;
    res           = '0;
    status        = '0;

    case (state)
      bba_pkg::ST_CLEAR: begin
        // Sweep the map to zero, one word a cycle
        status.clearing = 1'b1;
        mem_req.we      = 1'b1;
        mem_req.waddr   = clr_addr;
        mem_req.wdata   = '0;
        clr_addr_next   = clr_addr + AW'(1);
        if (clr_addr == {AW{1'b1}}) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end

      bba_pkg::ST_IDLE: begin
        status.in_ready = 1'b1;
        if (in_valid) begin
          tgt_next     = in_index;
          res_idx_next = '0;
          res_ok_next  = 1'b0;
          rd_addr_next = '0;
          if (in_action == bba_pkg::ACT_FREE) begin
            if ({1'b0, in_index} < lim) begin
              state_next = bba_pkg::ST_FREE_RD;
            end else begin
              state_next = bba_pkg::ST_DONE;
            end
          end else begin
            state_next = bba_pkg::ST_SCAN;
          end
        end
      end

      bba_pkg::ST_SCAN: begin
        if (hit) begin
          // Claim the lowest free block of this word
          mem_req.we    = 1'b1;
          mem_req.waddr = rd_word;
          mem_req.wdata = mem_rdata | (WB'(1) << hit_bit);
          res_ok_next   = 1'b1;
          res_idx_next  = bba_pkg::IDX_W'({rd_word, hit_bit});
          state_next    = bba_pkg::ST_DONE;
        end else if (!more) begin
          // Map full below the limit
          res_ok_next  = 1'b0;
          res_idx_next = '0;
          state_next   = bba_pkg::ST_DONE;
        end else begin
          // Fetch the next word
          mem_req.raddr = rd_addr[AW-1:0];
          rd_word_next  = rd_addr[AW-1:0];
          rd_addr_next  = rd_addr + CW'(1);
          rd_pend_next  = 1'b1;
        end
      end

      bba_pkg::ST_FREE_RD: begin
        mem_req.raddr = tgt[bba_pkg::IDX_W-1:BW];
        state_next    = bba_pkg::ST_FREE_WR;
      end

      bba_pkg::ST_FREE_WR: begin
        // Clear the block bit and write the word back
        mem_req.we    = 1'b1;
        mem_req.waddr = tgt[bba_pkg::IDX_W-1:BW];
        mem_req.wdata = mem_rdata & ~(WB'(1) << tgt[BW-1:0]);
        res_ok_next   = 1'b1;
        res_idx_next  = '0;
        state_next    = bba_pkg::ST_DONE;
      end

      bba_pkg::ST_DONE: begin
        // Hold the result until the output register takes it
        res.valid = 1'b1;
        res.ok    = res_ok;
        res.idx   = res_idx;
        if (res_ready) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = bba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bitmap_block_allocator_core.sv -----
// Channel      | Dir | Payload                                  | Transaction
// s_axis       | in  | tuser[0] action, tdata[15:0] block_index | tvalid & tready
// m_axis       | out | tuser[0] success, tdata[15:0] index      | tvalid & tready
// cfg          | in  | data[16:0] block_limit                   | valid & ready
//
// Allocate: the map is scanned from word 0 for the first free block below the
// limit; the map RAM's one read port fetches one 32-bit word a cycle.
// Free: read, modify, write back. One request is in flight at a time.
// After reset the map is swept to zero, all 2048 words; s_axis_tready stays low.
// A result waits in an output register, so the next request may be accepted
// while m_axis is stalled; cfg is always ready.
//
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_map_ram, bba_ctrl and the assertion macro header.
`default_nettype none
`include "bitmap_block_allocator_core_macros.svh"

module bitmap_block_allocator_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [bba_pkg::IDX_W-1:0]       s_axis_tdata,  // [15:0] block_index
  input  wire logic                            s_axis_tuser,  // [0] action
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [bba_pkg::IDX_W-1:0]            m_axis_tdata,  // [15:0] allocated_index
  output logic                                 m_axis_tuser,  // [0] success
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bba_pkg::LIMIT_W-1:0]     cfg_data       // [16:0] block_limit
);

  logic [bba_pkg::LIMIT_W-1:0]   limit_reg;
  logic [bba_pkg::LIMIT_W-1:0]   eff_lim;
  bba_pkg::bba_mem_req_t         mem_req;
  logic [bba_pkg::WORD_BITS-1:0] mem_rdata;
  bba_pkg::bba_result_t          res;
  bba_pkg::bba_status_t          status;
  logic                          res_ready;

  // Block limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= bba_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_reg <= cfg_data;
    end
  end

  // Clamp the limit to the map capacity
  assign eff_lim = (limit_reg > bba_pkg::LIMIT_MAX) ? bba_pkg::LIMIT_MAX : limit_reg;

  bba_map_ram u_map (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_index  (s_axis_tdata),
    .lim       (eff_lim),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res       (res),
    .res_ready (res_ready),
    .status    (status)
  );

  assign s_axis_tready = status.in_ready;

  // Output register: load when empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_axis_tdata <= res.idx;
      m_axis_tuser <= res.ok;
    end
  end

  // Checks
  `BBA_ASSERT(a_no_accept_in_clear, clk, rst, status.clearing |-> !s_axis_tready, "request accepted during map clear")
  `BBA_ASSERT(a_fail_zero_index, clk, rst, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0), "failed result with nonzero index")
  `BBA_ASSERT(a_one_in_flight, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second request taken while one is in flight")
  `BBA_ASSERT_NEVER(a_result_while_idle, clk, rst, res.valid && s_axis_tready, "result offered while idle")

endmodule

`default_nettype wire

// ----- test/tb_bitmap_block_allocator_core.sv -----
// Self-checking testbench for bitmap_block_allocator_core: first-fit allocate and free requests
// go in on the s_axis stream, and each result is checked against a behavioral copy of the map.
// Depends on bba_pkg and the allocator RTL only.
module tb_bitmap_block_allocator_core;

  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic                      act;
    logic [bba_pkg::IDX_W-1:0] idx;
  } request_t;

  typedef struct {
    logic                      ok;
    logic [bba_pkg::IDX_W-1:0] idx;
  } grant_t;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [bba_pkg::IDX_W-1:0]   s_axis_tdata;   // [15:0] block_index
  logic                        s_axis_tuser;   // [0] action
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [bba_pkg::IDX_W-1:0]   m_axis_tdata;   // [15:0] allocated_index
  logic                        m_axis_tuser;   // [0] success
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [bba_pkg::LIMIT_W-1:0] cfg_data;       // [16:0] block_limit

  // Shadow of the usage map and the limit register
  logic [bba_pkg::WORD_BITS-1:0] usage_words [0:bba_pkg::MAP_WORDS-1];
  logic [bba_pkg::LIMIT_W-1:0]   limit_now;

  request_t    request_q[$];
  grant_t      grant_q[$];
  logic        req_fire = 1'b0;
  logic        steady = 1'b0;
  int unsigned stall_asked = 0;
  int unsigned stall_served = 0;
  int unsigned stall_left = 0;
  int unsigned allocs_queued = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned n_granted = 0;
  int unsigned n_refused = 0;
  int unsigned n_freed = 0;
  int unsigned n_ignored = 0;
  int unsigned n_limits = 0;

  bitmap_block_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  // Apply one request to the shadow map and return the result it must produce
  function automatic grant_t serve_request(input logic act,
                                           input logic [bba_pkg::IDX_W-1:0] blk);
    grant_t      g;
    int unsigned span;
    int unsigned n;
    g.ok  = 1'b0;
    g.idx = '0;
    span = (limit_now > bba_pkg::LIMIT_CAP) ? bba_pkg::LIMIT_CAP : limit_now;
    if (act == bba_pkg::ACT_ALLOC) begin
      for (int unsigned w = 0; w < (span + 31) / 32 && !g.ok; w++) begin
        if (~usage_words[w] == '0) continue;
        for (int unsigned b = 0; b < bba_pkg::WORD_BITS && !g.ok; b++) begin
          n = w * bba_pkg::WORD_BITS + b;
          if (n < span && !usage_words[w][b]) begin
            usage_words[w][b] = 1'b1;
            g.ok  = 1'b1;
            g.idx = n[bba_pkg::IDX_W-1:0];
          end
        end
      end
    end else if (blk < span) begin
      usage_words[blk[15:5]][blk[4:0]] = 1'b0;
      g.ok = 1'b1;
    end
    return g;
  endfunction

  // Sender: offer queued requests, idle now and then, hold data until taken
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (!s_axis_tvalid || req_fire) begin
      if (request_q.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
        nxt = request_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.act;
        s_axis_tdata  <= nxt.idx;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_served != stall_asked) begin
      m_axis_tready <= 1'b0;
      stall_left    <= HOLD_CYCLES - 1;
      stall_served  <= stall_served + 1;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 9);
    end
  end

  // Sample transactions: check results, predict accepted requests, track the limit
  always @(posedge clk) begin : watch_ports
    grant_t want;
    grant_t outcome;
    req_fire = !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (grant_q.size() == 0) begin
        flag_error($sformatf("unexpected result success=%0b index=%0d",
                             m_axis_tuser, m_axis_tdata));
      end else begin
        want = grant_q.pop_front();
        if (m_axis_tuser !== want.ok)
          flag_error($sformatf("success %0b, want %0b", m_axis_tuser, want.ok));
        if (m_axis_tdata !== want.idx)
          flag_error($sformatf("allocated_index %0d, want %0d", m_axis_tdata, want.idx));
      end
    end
    if (req_fire) begin
      outcome = serve_request(s_axis_tuser, s_axis_tdata);
      grant_q.push_back(outcome);
      if (s_axis_tuser == bba_pkg::ACT_ALLOC) begin
        if (outcome.ok) n_granted++;
        else n_refused++;
      end else if (outcome.ok) begin
        n_freed++;
      end else begin
        n_ignored++;
      end
    end
    if (!rst && cfg_valid && cfg_ready) limit_now = cfg_data;
  end

  task automatic push_req(input logic act, input logic [bba_pkg::IDX_W-1:0] idx);
    request_t r;
    r.act = act;
    r.idx = idx;
    if (act == bba_pkg::ACT_ALLOC) allocs_queued++;
    request_q.push_back(r);
  endtask

  // Wait until every request is taken and every result has come back
  task automatic settle();
    do @(negedge clk);
    while (request_q.size() != 0 || s_axis_tvalid || grant_q.size() != 0);
  endtask

  task automatic write_limit(input logic [bba_pkg::LIMIT_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_limits++;
  endtask

  // Mostly allocates and frees of blocks likely in use, some noise and frees at the limit
  task automatic queue_random(input int count, input int unsigned lim);
    int unsigned roll;
    int unsigned near_idx;
    logic        act;
    logic [bba_pkg::IDX_W-1:0] idx;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      act  = (roll < 55) ? bba_pkg::ACT_ALLOC : bba_pkg::ACT_FREE;
      idx  = 16'($urandom);
      if (roll >= 55 && roll < 85) begin
        idx = 16'($urandom_range(0, allocs_queued + 8));
      end else if (roll >= 95) begin
        near_idx = lim + $urandom_range(0, 2) - 1;
        idx      = near_idx[bba_pkg::IDX_W-1:0];
      end
      push_req(act, idx);
    end
  endtask

  initial begin : stimulus
    int unsigned lim_pick;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = bba_pkg::ACT_ALLOC;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    limit_now     = bba_pkg::LIMIT_RESET;
    for (int w = 0; w < bba_pkg::MAP_WORDS; w++) usage_words[w] = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Reset limit: first-fit order, double free, frees at and above the limit
    push_req(bba_pkg::ACT_ALLOC, 16'hFFFF);
    push_req(bba_pkg::ACT_ALLOC, 16'h0000);
    push_req(bba_pkg::ACT_ALLOC, 16'h5555);
    push_req(bba_pkg::ACT_FREE, 16'd1);
    push_req(bba_pkg::ACT_FREE, 16'd1);
    push_req(bba_pkg::ACT_ALLOC, 16'hAAAA);
    push_req(bba_pkg::ACT_FREE, 16'd65535);
    push_req(bba_pkg::ACT_FREE, 16'd65454);
    push_req(bba_pkg::ACT_FREE, 16'd65453);
    push_req(bba_pkg::ACT_FREE, 16'd0);
    push_req(bba_pkg::ACT_FREE, 16'hAAAA);

    // Zero limit: nothing usable
    write_limit(17'd0);
    push_req(bba_pkg::ACT_ALLOC, 16'd0);
    push_req(bba_pkg::ACT_FREE, 16'd0);

    // One block: fill it, refuse, free, refill, free beyond the limit
    write_limit(17'd1);
    push_req(bba_pkg::ACT_ALLOC, 16'd0);
    push_req(bba_pkg::ACT_ALLOC, 16'd0);
    push_req(bba_pkg::ACT_FREE, 16'd0);
    push_req(bba_pkg::ACT_ALLOC, 16'd0);
    push_req(bba_pkg::ACT_FREE, 16'd1);

    // Limit inside the first word with every usable block taken
    write_limit(17'd3);
    push_req(bba_pkg::ACT_ALLOC, 16'd0);
    push_req(bba_pkg::ACT_FREE, 16'd2);
    push_req(bba_pkg::ACT_ALLOC, 16'd0);

    // Largest register value clamps to the full index span
    write_limit(17'h1FFFF);
    push_req(bba_pkg::ACT_FREE, 16'd65535);
    push_req(bba_pkg::ACT_ALLOC, 16'd0);

    // Random traffic, first stretch with no idling on either side
    write_limit(17'd65536);
    steady = 1'b1;
    queue_random(60, 65536);
    settle();
    steady = 1'b0;

    lim_pick = $urandom_range(1, 200);
    write_limit(17'(lim_pick));
    queue_random(60, lim_pick);

    // Long receiver hold-off while requests keep coming
    write_limit(17'd65535);
    queue_random(50, 65535);
    stall_asked++;

    write_limit(17'd40);
    queue_random(60, 40);

    lim_pick = $urandom_range(65537, 131071);
    write_limit(17'(lim_pick));
    queue_random(40, lim_pick);

    settle();
    repeat (2100) @(negedge clk);

    $display("Ran %0d requests under %0d limit settings, with one %0d-cycle output hold-off.",
             n_granted + n_refused + n_freed + n_ignored, n_limits + 1, HOLD_CYCLES);
    $display("Allocations granted %0d, refused %0d; frees accepted %0d, out of range %0d.",
             n_granted, n_refused, n_freed, n_ignored);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("Timed out with %0d results outstanding.", grant_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_map_ram.sv
rtl/bba_ctrl.sv
rtl/bitmap_block_allocator_core.sv
test/tb_bitmap_block_allocator_core.sv
